[design/ray_quad_hit_uv_defines.svh]
// ----------------------------------------------------------------------------
// ray_quad_hit_uv assertion macros
// Shared property forms for the ray/quad hit checker.
// ----------------------------------------------------------------------------
`ifndef RAY_QUAD_HIT_UV_DEFINES_SVH
`define RAY_QUAD_HIT_UV_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RQH_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rqh check failed");

// implication with a fixed latency written in cons
`define RQH_ASSERT_SEQ(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("rqh latency check failed");

`endif

[design/rqh_pkg.sv]
// ----------------------------------------------------------------------------
// rqh_pkg
// Types and constants of the ray/quad hit pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rqh_pkg;

   localparam int PARALLEL_EPS = 7;
   localparam int COORD_HALF   = 32768;
   localparam int DIV_STEPS    = 16;
   localparam int LATENCY      = 25;

   localparam logic [47:0] CENTRE_RST = 48'd0;
   localparam logic [47:0] AXIS_U_RST = 48'd256;
   localparam logic [47:0] AXIS_V_RST = 48'd16777216;
   localparam logic [47:0] AXIS_N_RST = 48'd1099511627776;
   localparam logic [15:0] EXTENT_RST = 16'd256;

   typedef enum logic [2:0] {
      CSR_CENTRE = 3'd0,
      CSR_AXIS_U = 3'd1,
      CSR_AXIS_V = 3'd2,
      CSR_AXIS_N = 3'd3,
      CSR_WIDTH  = 3'd4,
      CSR_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [47:0] centre_packed;
      logic [47:0] axis_u_packed;
      logic [47:0] axis_v_packed;
      logic [47:0] axis_n_packed;
      logic [15:0] width;
      logic [15:0] height;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] ray_org_x;
      logic signed [15:0] ray_org_y;
      logic signed [15:0] ray_org_z;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
      logic signed [15:0] ray_dir_z;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] coord_u;
      logic [15:0] coord_v;
   } rsp_type;

   typedef struct packed {
      logic signed [32:0] denom;
      logic signed [32:0] du;
      logic signed [32:0] dv;
      logic signed [33:0] num;
      logic signed [33:0] vu;
      logic signed [33:0] vv;
   } front_type;

   typedef struct packed {
      logic [63:0] n;
      logic [47:0] d;
      logic        neg;
   } div_in_type;

   typedef struct packed {
      logic [15:0] q;
      logic        rem_nz;
      logic        neg;
   } div_out_type;

   typedef struct packed {
      logic       hit;
      div_in_type u;
      div_in_type v;
   } cross_type;

endpackage

`default_nettype wire

[design/rqh_front.sv]
// ----------------------------------------------------------------------------
// rqh_front
// Three stages of dot products: denominator, direction and offset terms.
// ----------------------------------------------------------------------------
`default_nettype none

module rqh_front import rqh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  req_type   in_item,
   output logic      out_valid,
   output front_type out_data
);

   logic signed [15:0] org [3];
   logic signed [15:0] dir [3];
   logic signed [15:0] cen [3];
   logic signed [15:0] au  [3];
   logic signed [15:0] av  [3];
   logic signed [15:0] an  [3];

   always_comb begin
      org[0] = in_item.ray_org_x;
      org[1] = in_item.ray_org_y;
      org[2] = in_item.ray_org_z;
      dir[0] = in_item.ray_dir_x;
      dir[1] = in_item.ray_dir_y;
      dir[2] = in_item.ray_dir_z;
      for (int i = 0; i < 3; i++) begin
         cen[i] = $signed(cfg.centre_packed[16*i +: 16]);
         au[i]  = $signed(cfg.axis_u_packed[16*i +: 16]);
         av[i]  = $signed(cfg.axis_v_packed[16*i +: 16]);
         an[i]  = $signed(cfg.axis_n_packed[16*i +: 16]);
      end
   end

   // stage A: offset vector and direction products
   logic               a_vld_ff;
   logic signed [16:0] vec_in [3];
   logic signed [16:0] vec_ff [3];
   logic signed [31:0] pdn_in [3];
   logic signed [31:0] pdn_ff [3];
   logic signed [31:0] pdu_in [3];
   logic signed [31:0] pdu_ff [3];
   logic signed [31:0] pdv_in [3];
   logic signed [31:0] pdv_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec_in[i] = 17'(cen[i]) - 17'(org[i]);
         pdn_in[i] = 32'(an[i]) * 32'(dir[i]);
         pdu_in[i] = 32'(au[i]) * 32'(dir[i]);
         pdv_in[i] = 32'(av[i]) * 32'(dir[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
      end
      vec_ff <= vec_in;
      pdn_ff <= pdn_in;
      pdu_ff <= pdu_in;
      pdv_ff <= pdv_in;
   end

   // stage B: direction sums, offset products
   logic               b_vld_ff;
   logic signed [32:0] den_in, den_ff, du_in, du_ff, dv_in, dv_ff;
   logic signed [32:0] pvn_in [3];
   logic signed [32:0] pvn_ff [3];
   logic signed [32:0] pvu_in [3];
   logic signed [32:0] pvu_ff [3];
   logic signed [32:0] pvv_in [3];
   logic signed [32:0] pvv_ff [3];

   always_comb begin
      den_in = 33'(pdn_ff[0]) + 33'(pdn_ff[1]) + 33'(pdn_ff[2]);
      du_in  = 33'(pdu_ff[0]) + 33'(pdu_ff[1]) + 33'(pdu_ff[2]);
      dv_in  = 33'(pdv_ff[0]) + 33'(pdv_ff[1]) + 33'(pdv_ff[2]);
      for (int i = 0; i < 3; i++) begin
         pvn_in[i] = 33'(vec_ff[i]) * 33'(an[i]);
         pvu_in[i] = 33'(vec_ff[i]) * 33'(au[i]);
         pvv_in[i] = 33'(vec_ff[i]) * 33'(av[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      den_ff <= den_in;
      du_ff  <= du_in;
      dv_ff  <= dv_in;
      pvn_ff <= pvn_in;
      pvu_ff <= pvu_in;
      pvv_ff <= pvv_in;
   end

   // stage C: offset sums
   logic      c_vld_ff;
   front_type c_in, c_ff;

   always_comb begin
      c_in.denom = den_ff;
      c_in.du    = du_ff;
      c_in.dv    = dv_ff;
      c_in.num   = 34'(pvn_ff[0]) + 34'(pvn_ff[1]) + 34'(pvn_ff[2]);
      c_in.vu    = 34'(pvu_ff[0]) + 34'(pvu_ff[1]) + 34'(pvu_ff[2]);
      c_in.vv    = 34'(pvv_ff[0]) + 34'(pvv_ff[1]) + 34'(pvv_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_ff <= c_in;
   end

   assign out_valid = c_vld_ff;
   assign out_data  = c_ff;

endmodule

`default_nettype wire

[design/rqh_cross.sv]
// ----------------------------------------------------------------------------
// rqh_cross
// Five stages: miss tests, split wide products, differences and extent test.
// ----------------------------------------------------------------------------
`default_nettype none

module rqh_cross import rqh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output cross_type out_data
);

   // stage D: abs denominator, miss flags, partial products
   logic               d_vld_ff, dneg_d_ff, miss_d_ff;
   logic               dneg_in, par_in, behind_in;
   logic [32:0]        den_neg;
   logic [31:0]        aden_in, aden_d_ff;
   logic signed [16:0] num_hi;
   logic signed [17:0] num_lo;
   logic signed [15:0] den_hi;
   logic signed [17:0] den_lo;
   logic signed [49:0] pua_in, pua_ff, pva_in, pva_ff, puc_in, puc_ff, pvc_in, pvc_ff;
   logic signed [50:0] pub_in, pub_ff, pvb_in, pvb_ff;
   logic signed [51:0] pud_in, pud_ff, pvd_in, pvd_ff;

   always_comb begin
      dneg_in   = in_data.denom < 0;
      den_neg   = -in_data.denom;
      aden_in   = dneg_in ? den_neg[31:0] : in_data.denom[31:0];
      par_in    = aden_in <= 32'(PARALLEL_EPS);
      behind_in = dneg_in ? (in_data.num > 0) : (in_data.num < 0);
      num_hi    = $signed(in_data.num[33:17]);
      num_lo    = $signed({1'b0, in_data.num[16:0]});
      den_hi    = $signed(in_data.denom[32:17]);
      den_lo    = $signed({1'b0, in_data.denom[16:0]});
      pua_in    = 50'(in_data.du) * 50'(num_hi);
      pub_in    = 51'(in_data.du) * 51'(num_lo);
      puc_in    = 50'(in_data.vu) * 50'(den_hi);
      pud_in    = 52'(in_data.vu) * 52'(den_lo);
      pva_in    = 50'(in_data.dv) * 50'(num_hi);
      pvb_in    = 51'(in_data.dv) * 51'(num_lo);
      pvc_in    = 50'(in_data.vv) * 50'(den_hi);
      pvd_in    = 52'(in_data.vv) * 52'(den_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= in_valid;
      end
      dneg_d_ff <= dneg_in;
      miss_d_ff <= par_in | behind_in;
      aden_d_ff <= aden_in;
      pua_ff <= pua_in;
      pub_ff <= pub_in;
      puc_ff <= puc_in;
      pud_ff <= pud_in;
      pva_ff <= pva_in;
      pvb_ff <= pvb_in;
      pvc_ff <= pvc_in;
      pvd_ff <= pvd_in;
   end

   // stage E: divisor and full products
   logic               e_vld_ff, dneg_e_ff, miss_e_ff;
   logic [15:0]        weff, heff;
   logic [47:0]        dw_in, dw_e_ff, dh_in, dh_e_ff;
   logic signed [67:0] pu1_in, pu1_ff, pu2_in, pu2_ff, pv1_in, pv1_ff, pv2_in, pv2_ff;

   always_comb begin
      weff   = (cfg.width == '0) ? 16'd1 : cfg.width;
      heff   = (cfg.height == '0) ? 16'd1 : cfg.height;
      dw_in  = 48'(aden_d_ff) * 48'(weff);
      dh_in  = 48'(aden_d_ff) * 48'(heff);
      pu1_in = (68'(pua_ff) <<< 17) + 68'(pub_ff);
      pu2_in = (68'(puc_ff) <<< 17) + 68'(pud_ff);
      pv1_in = (68'(pva_ff) <<< 17) + 68'(pvb_ff);
      pv2_in = (68'(pvc_ff) <<< 17) + 68'(pvd_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      dneg_e_ff <= dneg_d_ff;
      miss_e_ff <= miss_d_ff;
      dw_e_ff   <= dw_in;
      dh_e_ff   <= dh_in;
      pu1_ff    <= pu1_in;
      pu2_ff    <= pu2_in;
      pv1_ff    <= pv1_in;
      pv2_ff    <= pv2_in;
   end

   // stage F: differences
   logic               f_vld_ff, dneg_f_ff, miss_f_ff;
   logic [47:0]        dw_f_ff, dh_f_ff;
   logic signed [67:0] diffu_ff, diffv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= e_vld_ff;
      end
      dneg_f_ff <= dneg_e_ff;
      miss_f_ff <= miss_e_ff;
      dw_f_ff   <= dw_e_ff;
      dh_f_ff   <= dh_e_ff;
      diffu_ff  <= pu1_ff - pu2_ff;
      diffv_ff  <= pv1_ff - pv2_ff;
   end

   // stage G: magnitudes and signs
   logic               g_vld_ff, miss_g_ff, negu_ff, negv_ff;
   logic               rawu, rawv;
   logic [47:0]        dw_g_ff, dh_g_ff;
   logic [67:0]        magu_in, magu_ff, magv_in, magv_ff;

   always_comb begin
      rawu    = diffu_ff < 0;
      rawv    = diffv_ff < 0;
      magu_in = rawu ? unsigned'(-diffu_ff) : unsigned'(diffu_ff);
      magv_in = rawv ? unsigned'(-diffv_ff) : unsigned'(diffv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= f_vld_ff;
      end
      miss_g_ff <= miss_f_ff;
      dw_g_ff   <= dw_f_ff;
      dh_g_ff   <= dh_f_ff;
      magu_ff   <= magu_in;
      magv_ff   <= magv_in;
      negu_ff   <= rawu ^ dneg_f_ff;
      negv_ff   <= ~(rawv ^ dneg_f_ff);
   end

   // stage H: half-extent test, divider operands
   logic      h_vld_ff;
   logic      inu, inv;
   cross_type h_in, h_ff;

   always_comb begin
      inu        = magu_ff <= {13'd0, dw_g_ff, 7'd0};
      inv        = magv_ff <= {13'd0, dh_g_ff, 7'd0};
      h_in.hit   = ~miss_g_ff & inu & inv;
      h_in.u.n   = {1'b0, magu_ff[54:0], 8'd0};
      h_in.u.d   = dw_g_ff;
      h_in.u.neg = negu_ff;
      h_in.v.n   = {1'b0, magv_ff[54:0], 8'd0};
      h_in.v.d   = dh_g_ff;
      h_in.v.neg = negv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
      h_ff <= h_in;
   end

   assign out_valid = h_vld_ff;
   assign out_data  = h_ff;

endmodule

`default_nettype wire

[design/rqh_div.sv]
// ----------------------------------------------------------------------------
// rqh_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rqh_div import rqh_pkg::*; (
   input  logic        clock,
   input  div_in_type  in_data,
   output div_out_type out_data
);

   logic [63:0] rem_ff [DIV_STEPS];
   logic [47:0] den_ff [DIV_STEPS];
   logic [15:0] q_ff   [DIV_STEPS];
   logic        neg_ff [DIV_STEPS];

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic [63:0] src_rem;
      logic [47:0] src_den;
      logic [15:0] src_q;
      logic        src_neg;
      logic [63:0] sh;
      logic        ge;

      if (g == 0) begin : g_head
         assign src_rem = in_data.n;
         assign src_den = in_data.d;
         assign src_q   = '0;
         assign src_neg = in_data.neg;
      end else begin : g_body
         assign src_rem = rem_ff[g-1];
         assign src_den = den_ff[g-1];
         assign src_q   = q_ff[g-1];
         assign src_neg = neg_ff[g-1];
      end

      assign sh = 64'(src_den) << (DIV_STEPS - 1 - g);
      assign ge = src_rem >= sh;

      always_ff @(posedge clock) begin
         rem_ff[g] <= ge ? src_rem - sh : src_rem;
         q_ff[g]   <= src_q | (16'(ge) << (DIV_STEPS - 1 - g));
         den_ff[g] <= src_den;
         neg_ff[g] <= src_neg;
      end
   end

   assign out_data.q      = q_ff[DIV_STEPS-1];
   assign out_data.rem_nz = |rem_ff[DIV_STEPS-1];
   assign out_data.neg    = neg_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

[design/ray_quad_hit_uv.sv]
// ----------------------------------------------------------------------------
// ray_quad_hit_uv
// Ray against rectangle test giving hit flag and flipped-v texture coords.
//
//   channel   ports                        handshake
//   request   start, busy, req_item        start & !busy
//   response  rsp_strobe, rsp_item         strobe, one cycle, no backpressure
//   config    csr_valid/ready/index/wdata  valid & ready
//
// One ray accepted per cycle while busy is low; each transfer yields one result.
// The pipeline: 3 dot-product stages, 5 product/compare stages, a 16-stage
// divider (one quotient bit per stage) and the output register.
// Reset is synchronous; busy is high only while reset is asserted.
// The response side has no stall, so nothing in the pipeline ever waits.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_quad_hit_uv import rqh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centre_packed <= CENTRE_RST;
         cfg_ff.axis_u_packed <= AXIS_U_RST;
         cfg_ff.axis_v_packed <= AXIS_V_RST;
         cfg_ff.axis_n_packed <= AXIS_N_RST;
         cfg_ff.width         <= EXTENT_RST;
         cfg_ff.height        <= EXTENT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTRE: cfg_ff.centre_packed <= csr_wdata;
            CSR_AXIS_U: cfg_ff.axis_u_packed <= csr_wdata;
            CSR_AXIS_V: cfg_ff.axis_v_packed <= csr_wdata;
            CSR_AXIS_N: cfg_ff.axis_n_packed <= csr_wdata;
            CSR_WIDTH:  cfg_ff.width         <= csr_wdata[15:0];
            CSR_HEIGHT: cfg_ff.height        <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = reset;

   logic      front_vld;
   front_type front_data;
   logic      cross_vld;
   cross_type cross_data;

   rqh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (start & ~busy),
      .in_item   (req_item),
      .out_valid (front_vld),
      .out_data  (front_data)
   );

   rqh_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_vld),
      .in_data   (front_data),
      .out_valid (cross_vld),
      .out_data  (cross_data)
   );

   div_out_type div_u, div_v;

   rqh_div u_div_u (
      .clock    (clock),
      .in_data  (cross_data.u),
      .out_data (div_u)
   );

   rqh_div u_div_v (
      .clock    (clock),
      .in_data  (cross_data.v),
      .out_data (div_v)
   );

   logic vld_ff [DIV_STEPS];
   logic hit_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= cross_vld;
         for (int i = 1; i < DIV_STEPS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      hit_ff[0] <= cross_data.hit;
      for (int i = 1; i < DIV_STEPS; i++) begin
         hit_ff[i] <= hit_ff[i-1];
      end
   end

   function automatic logic [15:0] finish_coord(input div_out_type r);
      logic [16:0]        qa;
      logic signed [17:0] val;
      qa  = {1'b0, r.q} + {16'd0, r.neg & r.rem_nz};
      val = r.neg ? 18'(COORD_HALF) - $signed({1'b0, qa})
                  : 18'(COORD_HALF) + $signed({1'b0, qa});
      if (val < 0) begin
         return '0;
      end else if (val > 18'sd65535) begin
         return '1;
      end
      return val[15:0];
   endfunction

   logic    strobe_ff;
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.hit     = hit_ff[DIV_STEPS-1];
      rsp_in.coord_u = rsp_in.hit ? finish_coord(div_u) : '0;
      rsp_in.coord_v = rsp_in.hit ? finish_coord(div_v) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[DIV_STEPS-1];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

[design/rqh_check.sv]
// ----------------------------------------------------------------------------
// rqh_check
// Port-level checks of the ray/quad hit block: latency, miss results and a known ray origin x.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_quad_hit_uv_defines.svh"

module rqh_check import rqh_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   logic [15:0] ray_x;

   assign ray_x = req_item.ray_org_x;

   // every transfer yields exactly one result strobe, and each strobe traces back to a transfer
   `RQH_ASSERT_SEQ(a_lat_fwd, start && !busy, ##25 rsp_strobe)
   `RQH_ASSERT_NOW(a_lat_back, rsp_strobe, $past(start && !busy, 25))
   // a miss carries zero coordinates
   `RQH_ASSERT_NOW(a_miss_zero, rsp_strobe && !rsp_item.hit,
                   rsp_item.coord_u == 16'd0 && rsp_item.coord_v == 16'd0)
   // ray_org_x is checked to be known, on a transfer only
   `RQH_ASSERT_NOW(a_req_known, start && !busy, !$isunknown(ray_x))

endmodule

bind ray_quad_hit_uv rqh_check u_rqh_check (.*);

`default_nettype wire
